/* hdl/bce_pkg.sv */
// Package: shared types, constants, polymod step and control store for the checksum engine.
package bce_pkg;

    localparam int MAX_PREFIX_DEF = 128;
    localparam int CHECK_SYMBOLS  = 6;
    localparam int RES_W          = 30;
    localparam int CHK_CNT_W      = $clog2(CHECK_SYMBOLS);

    // Input item kinds
    localparam logic [1:0] KIND_PREFIX  = 2'd0;
    localparam logic [1:0] KIND_VERSION = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;
    localparam logic [1:0] KIND_FINISH  = 2'd3;

    // Register index (byte address bit 2)
    localparam logic REG_VERIFY_MODE = 1'b0;

    localparam logic [RES_W-1:0] GEN [0:4] = '{
        30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
    };
    localparam logic [RES_W-1:0] CONST_M   = 30'h2bc830a3;
    localparam logic [RES_W-1:0] CONST_0   = 30'h00000001;
    localparam logic [RES_W-1:0] RES_RESET = 30'h00000001;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
    } in_item_t;

    typedef struct packed {
        logic [4:0] symbol;
        logic       passed;
        logic       error;
        logic       last;
    } out_item_t;

    typedef enum logic [1:0] {
        SYM_NONE,
        SYM_LATCHED,
        SYM_ZERO,
        SYM_MEM
    } sym_sel_t;

    typedef enum logic [2:0] {
        JMP_GOTO,
        JMP_DISPATCH,
        JMP_IF_EMPTY,
        JMP_LOOP_MEM,
        JMP_IF_FINISH,
        JMP_IF_VERIFY,
        JMP_LOOP_COUNT
    } jump_t;

    typedef enum logic [3:0] {
        UA_DISPATCH,
        UA_CLOSE_ZERO,
        UA_CLOSE_LOOP,
        UA_CLOSE_END,
        UA_APPLY,
        UA_FIN,
        UA_FIN_ZERO,
        UA_FIN_CHECK,
        UA_EMIT,
        UA_VERIFY
    } uaddr_t;

    typedef struct packed {
        sym_sel_t sym_sel;
        logic     set_seen;
        logic     apply_ver;
        logic     load_chk;
        logic     emit_sym;
        logic     emit_verify;
        logic     wait_out;
        jump_t    jump;
        uaddr_t   target;
    } ucode_t;

    typedef struct packed {
        logic     accept;
        sym_sel_t sym_sel;
        logic     set_seen;
        logic     apply_ver;
        logic     load_chk;
        logic     emit_sym;
        logic     emit_verify;
        logic     last;
    } dp_ctrl_t;

    typedef struct packed {
        logic payload_seen;
        logic prefix_empty;
        logic held_finish;
    } dp_stat_t;

    // One step of the 30-bit BCH polymod
    function automatic logic [RES_W-1:0] poly_step(input logic [RES_W-1:0] res,
                                                   input logic [4:0] sym);
        logic [RES_W-1:0] r;
        r = {res[24:0], sym};
        for (int i = 0; i < 5; i++) begin
            if (res[25+i]) r = r ^ GEN[i];
        end
        return r;
    endfunction

    // Control store: one word per microcode address
    function automatic ucode_t ucode_rom(input uaddr_t a);
        ucode_t w;
        w.sym_sel     = SYM_NONE;
        w.set_seen    = 1'b0;
        w.apply_ver   = 1'b0;
        w.load_chk    = 1'b0;
        w.emit_sym    = 1'b0;
        w.emit_verify = 1'b0;
        w.wait_out    = 1'b0;
        w.jump        = JMP_DISPATCH;
        w.target      = UA_DISPATCH;
        case (a)
            UA_DISPATCH: begin
                w.jump = JMP_DISPATCH;
            end
            UA_CLOSE_ZERO: begin
                w.sym_sel = SYM_ZERO;
                w.jump    = JMP_IF_EMPTY;
                w.target  = UA_CLOSE_END;
            end
            UA_CLOSE_LOOP: begin
                w.sym_sel = SYM_MEM;
                w.jump    = JMP_LOOP_MEM;
                w.target  = UA_CLOSE_END;
            end
            UA_CLOSE_END: begin
                w.set_seen = 1'b1;
                w.jump     = JMP_IF_FINISH;
                w.target   = UA_FIN;
            end
            UA_APPLY: begin
                w.sym_sel   = SYM_LATCHED;
                w.apply_ver = 1'b1;
                w.jump      = JMP_GOTO;
                w.target    = UA_DISPATCH;
            end
            UA_FIN: begin
                w.jump   = JMP_IF_VERIFY;
                w.target = UA_VERIFY;
            end
            UA_FIN_ZERO: begin
                w.sym_sel = SYM_ZERO;
                w.jump    = JMP_LOOP_COUNT;
                w.target  = UA_FIN_CHECK;
            end
            UA_FIN_CHECK: begin
                w.load_chk = 1'b1;
                w.jump     = JMP_GOTO;
                w.target   = UA_EMIT;
            end
            UA_EMIT: begin
                w.emit_sym = 1'b1;
                w.wait_out = 1'b1;
                w.jump     = JMP_LOOP_COUNT;
                w.target   = UA_DISPATCH;
            end
            UA_VERIFY: begin
                w.emit_verify = 1'b1;
                w.wait_out    = 1'b1;
                w.jump        = JMP_GOTO;
                w.target      = UA_DISPATCH;
            end
            default: begin
                w.jump = JMP_GOTO;
            end
        endcase
        return w;
    endfunction

endpackage

/* hdl/bce_seq.sv */
// Microcode sequencer: program counter, loop counter and jump logic.
module bce_seq import bce_pkg::*; #(
    parameter int LP_W   = 8,
    parameter int CNT_W  = 8,
    parameter int ADDR_W = 7
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        in_kind,
    input  logic              verify_mode,
    input  logic              out_free,
    input  dp_stat_t          stat,
    input  logic [CNT_W-1:0]  prefix_count,
    output dp_ctrl_t          ctrl,
    output logic [ADDR_W-1:0] rd_addr
);

    uaddr_t          pc_reg, pc_next, pc_inc;
    logic [LP_W-1:0] lp_reg, lp_next;
    ucode_t          uw;
    logic            stall, accept, stay, lp_final, mem_more;

    assign uw       = ucode_rom(pc_reg);
    assign stall    = uw.wait_out && !out_free;
    assign s_ready  = (uw.jump == JMP_DISPATCH);
    assign accept   = s_ready && s_valid;
    assign pc_inc   = uaddr_t'(pc_reg + 4'd1);
    assign lp_final = (lp_reg == LP_W'(CHECK_SYMBOLS - 1));
    assign mem_more = (({1'b0, lp_reg} + (LP_W+1)'(1)) < (LP_W+1)'(prefix_count));

    // Next address
    always_comb begin
        pc_next = pc_reg;
        stay    = 1'b0;
        if (!stall) begin
            case (uw.jump)
                JMP_GOTO: pc_next = uw.target;
                JMP_DISPATCH: begin
                    if (accept) begin
                        case (in_kind)
                            KIND_PREFIX: pc_next = UA_DISPATCH;
                            KIND_FINISH: pc_next = stat.payload_seen ? UA_FIN : UA_CLOSE_ZERO;
                            default:     pc_next = stat.payload_seen ? UA_DISPATCH
                                                                     : UA_CLOSE_ZERO;
                        endcase
                    end
                end
                JMP_IF_EMPTY:  pc_next = stat.prefix_empty ? uw.target : pc_inc;
                JMP_IF_FINISH: pc_next = stat.held_finish ? uw.target : pc_inc;
                JMP_IF_VERIFY: pc_next = verify_mode ? uw.target : pc_inc;
                JMP_LOOP_MEM: begin
                    if (mem_more) stay = 1'b1;
                    else          pc_next = uw.target;
                end
                JMP_LOOP_COUNT: begin
                    if (!lp_final) stay = 1'b1;
                    else           pc_next = uw.target;
                end
                default: pc_next = UA_DISPATCH;
            endcase
        end
    end

    always_comb begin
        if (stall)     lp_next = lp_reg;
        else if (stay) lp_next = lp_reg + LP_W'(1);
        else           lp_next = '0;
    end

    // Datapath controls
    always_comb begin
        ctrl.accept      = accept;
        ctrl.sym_sel     = stall ? SYM_NONE : uw.sym_sel;
        ctrl.set_seen    = uw.set_seen && !stall;
        ctrl.apply_ver   = uw.apply_ver && !stall;
        ctrl.load_chk    = uw.load_chk && !stall;
        ctrl.emit_sym    = uw.emit_sym && !stall;
        ctrl.emit_verify = uw.emit_verify && !stall;
        ctrl.last        = uw.emit_sym && lp_final;
        rd_addr          = lp_next[ADDR_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= UA_DISPATCH;
            lp_reg <= '0;
        end else begin
            pc_reg <= pc_next;
            lp_reg <= lp_next;
        end
    end

endmodule

/* hdl/bce_dp.sv */
// Datapath: residue, prefix store, message flags and checksum shift register.
module bce_dp import bce_pkg::*; #(
    parameter int MAX_PREFIX = MAX_PREFIX_DEF,
    parameter int CNT_W      = 8,
    parameter int ADDR_W     = 7
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  dp_ctrl_t          ctrl,
    input  in_item_t          in_item,
    input  logic              verify_mode,
    input  logic [ADDR_W-1:0] rd_addr,
    output dp_stat_t          stat,
    output logic [CNT_W-1:0]  prefix_count,
    output out_item_t         result
);

    logic [RES_W-1:0] residue_reg, residue_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             use_mod_reg, use_mod_next;
    logic             seen_reg, seen_next;
    logic             ovf_reg, ovf_next;
    logic             had_reg;
    in_item_t         held_reg;
    logic [RES_W-1:0] chk_reg;
    logic [4:0]       mem [MAX_PREFIX];
    logic [4:0]       rdata_reg;
    logic [RES_W-1:0] konst;
    logic             prefix_ok, clear;

    function automatic logic mod_of(input logic vmode, input logic [7:0] v);
        return vmode ? (v[4:0] != 5'd0) : (v != 8'd0);
    endfunction

    assign prefix_ok = (in_item.kind == KIND_PREFIX) && !seen_reg
                       && (count_reg < CNT_W'(MAX_PREFIX));
    assign clear     = ctrl.emit_verify || (ctrl.emit_sym && ctrl.last);
    assign konst     = use_mod_reg ? CONST_M : CONST_0;

    always_comb begin
        residue_next = residue_reg;
        count_next   = count_reg;
        use_mod_next = use_mod_reg;
        seen_next    = seen_reg;
        ovf_next     = ovf_reg;
        if (clear) begin
            residue_next = RES_RESET;
            count_next   = '0;
            use_mod_next = 1'b0;
            seen_next    = 1'b0;
            ovf_next     = 1'b0;
        end else if (ctrl.accept) begin
            case (in_item.kind)
                KIND_PREFIX: begin
                    if (prefix_ok) begin
                        residue_next = poly_step(residue_reg, {2'b00, in_item.value[7:5]});
                        count_next   = count_reg + CNT_W'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                end
                KIND_VERSION: begin
                    if (seen_reg) begin
                        residue_next = poly_step(residue_reg, in_item.value[4:0]);
                        use_mod_next = mod_of(verify_mode, in_item.value);
                    end
                end
                KIND_PAYLOAD: begin
                    if (seen_reg) residue_next = poly_step(residue_reg, in_item.value[4:0]);
                end
                default: ;
            endcase
        end else begin
            case (ctrl.sym_sel)
                SYM_LATCHED: residue_next = poly_step(residue_reg, held_reg.value[4:0]);
                SYM_ZERO:    residue_next = poly_step(residue_reg, 5'd0);
                SYM_MEM:     residue_next = poly_step(residue_reg, rdata_reg);
                default: ;
            endcase
            if (ctrl.set_seen) seen_next = 1'b1;
            if (ctrl.apply_ver && (held_reg.kind == KIND_VERSION)) begin
                use_mod_next = mod_of(verify_mode, held_reg.value);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            residue_reg <= RES_RESET;
            count_reg   <= '0;
            use_mod_reg <= 1'b0;
            seen_reg    <= 1'b0;
            ovf_reg     <= 1'b0;
        end else begin
            residue_reg <= residue_next;
            count_reg   <= count_next;
            use_mod_reg <= use_mod_next;
            seen_reg    <= seen_next;
            ovf_reg     <= ovf_next;
        end
    end

    // Latched item and checksum shift register
    always_ff @(posedge aclk) begin
        if (ctrl.accept) begin
            held_reg <= in_item;
            had_reg  <= seen_reg;
        end
        if (ctrl.load_chk)      chk_reg <= residue_reg ^ konst;
        else if (ctrl.emit_sym) chk_reg <= {chk_reg[RES_W-6:0], 5'd0};
    end

    // Prefix low-part store
    always_ff @(posedge aclk) begin
        if (ctrl.accept && prefix_ok) mem[count_reg[ADDR_W-1:0]] <= in_item.value[4:0];
        rdata_reg <= mem[rd_addr];
    end

    always_comb begin
        result = '0;
        if (ctrl.emit_verify) begin
            result.passed = had_reg && (count_reg != '0) && (residue_reg == konst);
            result.last   = 1'b1;
        end else begin
            result.symbol = chk_reg[RES_W-1:RES_W-5];
            result.last   = ctrl.last;
        end
        result.error = ovf_reg;
    end

    assign stat.payload_seen = seen_reg;
    assign stat.prefix_empty = (count_reg == '0);
    assign stat.held_finish  = (held_reg.kind == KIND_FINISH);
    assign prefix_count      = count_reg;

endmodule

/* hdl/bech32_checksum_engine_core.sv */
// Top level: bech32/bech32m checksum engine with register port and output register.
// One item per cycle while s_ready is high; the first version or payload item after a prefix holds
// the input for the prefix replay, and a finish that closes the prefix holds it for the replay too.
// Finish holds the input until its result or symbols are emitted; m_ready stalls add more.
// After a finish: FIN then VERIFY in verify mode, FIN_ZERO, FIN_CHECK and EMIT in generate.
// Synchronous aresetn clears sequencer, message state and output register; prefix store kept.
module bech32_checksum_engine_core import bce_pkg::*; #(
    parameter int MAX_PREFIX = MAX_PREFIX_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CNT_W  = $clog2(MAX_PREFIX + 1);
    localparam int ADDR_W = (MAX_PREFIX > 1) ? $clog2(MAX_PREFIX) : 1;
    localparam int LP_W   = (CNT_W > CHK_CNT_W) ? CNT_W : CHK_CNT_W;

    logic              verify_mode_reg;
    logic              m_valid_reg;
    out_item_t         m_data_reg;
    dp_ctrl_t          ctrl;
    dp_stat_t          stat;
    logic [CNT_W-1:0]  prefix_count;
    logic [ADDR_W-1:0] rd_addr;
    out_item_t         result;
    logic              out_free, emit;

    // Register port: single-register decode on the word index, no wait states
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_VERIFY_MODE) ? {31'd0, verify_mode_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            verify_mode_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_VERIFY_MODE)) begin
            verify_mode_reg <= pwdata[0];
        end
    end

    // The output register frees up in the same cycle its transfer completes
    assign out_free = !m_valid_reg || m_ready;
    assign emit     = ctrl.emit_sym || ctrl.emit_verify;

    bce_seq #(
        .LP_W   (LP_W),
        .CNT_W  (CNT_W),
        .ADDR_W (ADDR_W)
    ) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .in_kind      (s_data.kind),
        .verify_mode  (verify_mode_reg),
        .out_free     (out_free),
        .stat         (stat),
        .prefix_count (prefix_count),
        .ctrl         (ctrl),
        .rd_addr      (rd_addr)
    );

    bce_dp #(
        .MAX_PREFIX (MAX_PREFIX),
        .CNT_W      (CNT_W),
        .ADDR_W     (ADDR_W)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctrl         (ctrl),
        .in_item      (s_data),
        .verify_mode  (verify_mode_reg),
        .rd_addr      (rd_addr),
        .stat         (stat),
        .prefix_count (prefix_count),
        .result       (result)
    );

    // Output register: load on emit, drop once the transfer completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) m_data_reg <= result;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* hdl/bce_checker.sv */
// Port-level checker for the checksum engine, bound to the top level.
module bce_checker import bce_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed or dropped while stalled");

    a_finish_stalls: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.kind == KIND_FINISH) |=> !s_ready)
        else $error("input taken in the cycle after a finish transfer");

    a_pass_is_final: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.passed |-> m_data.last && (m_data.symbol == 5'd0))
        else $error("pass flag on a result that is not a lone verify result");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

endmodule

bind bech32_checksum_engine_core bce_checker u_bce_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

/* test/tb_top.sv */
// Testbench for the bech32/bech32m checksum engine: directed table, random messages, scoreboard.
module tb_top;
    import bce_pkg::*;

    // Generator taps of the 30-bit BCH code and the two final constants
    localparam logic [29:0] TAP0       = 30'h3b6a57b2;
    localparam logic [29:0] TAP1       = 30'h26508e6d;
    localparam logic [29:0] TAP2       = 30'h1ea119fa;
    localparam logic [29:0] TAP3       = 30'h3d4233dd;
    localparam logic [29:0] TAP4       = 30'h2a1462b3;
    localparam logic [29:0] BECH32M_K  = 30'h2bc830a3;
    localparam logic [29:0] BECH32_K   = 30'h00000001;

    localparam int          HRP_MAX      = MAX_PREFIX_DEF;
    localparam int          CHK_LEN      = CHECK_SYMBOLS;
    localparam logic [2:0]  MODE_ADDR    = {REG_VERIFY_MODE, 2'b00};
    localparam int          PHASE_ITEMS  = 20;
    localparam int          PHASE_COUNT  = 2;
    localparam int          SETTLE_TICKS = 40;
    localparam int          HOLD_TICKS   = 2000;
    localparam int          CYCLE_LIMIT  = 400000;

    // Verdicts that can be read straight off the rules: a verify finish that fails on
    // emptiness, with and without the prefix error flag
    localparam out_item_t VERDICT_EMPTY =
        '{symbol: 5'd0, passed: 1'b0, error: 1'b0, last: 1'b1};
    localparam out_item_t VERDICT_EMPTY_ERR =
        '{symbol: 5'd0, passed: 1'b0, error: 1'b1, last: 1'b1};

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_data;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    bech32_checksum_engine_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Checksum tracker: mirrors the engine's message state
    // ------------------------------------------------------------------
    logic [29:0] bch_res;
    logic [4:0]  hrp_low [HRP_MAX];
    int          hrp_len;
    bit          use_bech32m;
    bit          data_seen;
    bit          hrp_fault;
    bit          mode_verify;
    out_item_t   next_out [CHK_LEN];
    out_item_t   chk_due [$];

    // Bookkeeping shared between the stimulus, receiver and scoreboard
    int          cycles;
    int          faults;
    int          tx_count;
    int          rx_count;
    int          pass_count;
    int          err_count;
    int          msg_count;
    bit          tx_calm;
    bit          rx_calm;
    bit          hold_req;
    in_item_t    msg_q [$];

    typedef struct {
        bit        cfg;     // register write rather than an item
        in_item_t  item;
        int        reps;
        bit        typed;   // expected result given in the row
        out_item_t want;
    } step_row_t;

    step_row_t   dir_rows [$];

    // Shift in one 5-bit symbol; the five bits pushed out select the taps to fold back
    function automatic logic [29:0] bch_mix(input logic [29:0] r, input logic [4:0] s);
        return {r[24:0], s}
            ^ ({30{r[25]}} & TAP0) ^ ({30{r[26]}} & TAP1) ^ ({30{r[27]}} & TAP2)
            ^ ({30{r[28]}} & TAP3) ^ ({30{r[29]}} & TAP4);
    endfunction

    function automatic void clear_msg();
        bch_res     = BECH32_K;
        hrp_len     = 0;
        use_bech32m = 1'b0;
        data_seen   = 1'b0;
        hrp_fault   = 1'b0;
    endfunction

    // Complete the prefix expansion: a zero separator, then the stored low parts
    function automatic void close_hrp();
        if (data_seen) return;
        bch_res = bch_mix(bch_res, 5'd0);
        for (int i = 0; i < hrp_len; i++) bch_res = bch_mix(bch_res, hrp_low[i]);
        data_seen = 1'b1;
    endfunction

    // Advance the tracker by one accepted item; return how many results it causes
    function automatic int bch_track_item(input in_item_t it);
        bit          had;
        logic [29:0] konst;
        logic [29:0] word;
        int          n;
        n = 0;
        case (it.kind)
            KIND_PREFIX: begin
                if (data_seen || hrp_len >= HRP_MAX) begin
                    hrp_fault = 1'b1;
                end else begin
                    bch_res = bch_mix(bch_res, {2'b00, it.value[7:5]});
                    hrp_low[hrp_len] = it.value[4:0];
                    hrp_len++;
                end
            end
            KIND_VERSION: begin
                close_hrp();
                use_bech32m = mode_verify ? (it.value[4:0] != 5'd0) : (it.value != 8'd0);
                bch_res = bch_mix(bch_res, it.value[4:0]);
            end
            KIND_PAYLOAD: begin
                close_hrp();
                bch_res = bch_mix(bch_res, it.value[4:0]);
            end
            default: begin
                had = data_seen;
                close_hrp();
                konst = use_bech32m ? BECH32M_K : BECH32_K;
                if (mode_verify) begin
                    next_out[0] = '{symbol: 5'd0,
                                    passed: had && hrp_len != 0 && bch_res == konst,
                                    error:  hrp_fault,
                                    last:   1'b1};
                    n = 1;
                end else begin
                    repeat (CHK_LEN) bch_res = bch_mix(bch_res, 5'd0);
                    word = bch_res ^ konst;
                    for (int k = 0; k < CHK_LEN; k++) begin
                        next_out[k] = '{symbol: word[29-5*k -: 5], passed: 1'b0,
                                        error: hrp_fault, last: k == CHK_LEN - 1};
                    end
                    n = CHK_LEN;
                end
                clear_msg();
            end
        endcase
        return n;
    endfunction

    function automatic void note_fault(input string what);
        faults++;
        if (faults <= 10) $display("[cycle %0d] %s", cycles, what);
    endfunction

    function automatic in_item_t mk_item(input logic [1:0] k, input logic [7:0] v);
        in_item_t it;
        it.kind  = k;
        it.value = v;
        return it;
    endfunction

    function automatic void add_row(input bit cfg, input logic [1:0] k, input logic [7:0] v,
                                    input int reps = 1, input bit typed = 1'b0,
                                    input out_item_t want = '0);
        step_row_t row;
        row.cfg   = cfg;
        row.item  = mk_item(k, v);
        row.reps  = reps;
        row.typed = typed;
        row.want  = want;
        dir_rows.push_back(row);
    endfunction

    // ------------------------------------------------------------------
    // Input channel and register port
    // ------------------------------------------------------------------

    // Offer one item after a random gap and hold it until the transfer; then predict
    task automatic send_item(input in_item_t it, input bit typed = 1'b0,
                             input out_item_t want = '0);
        int gap;
        int n;
        gap = tx_calm ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (s_ready !== 1'b1);
        tx_count++;
        n = bch_track_item(it);
        if (typed) begin
            chk_due.push_back(want);
        end else begin
            for (int k = 0; k < n; k++) chk_due.push_back(next_out[k]);
        end
    endtask

    // Drop valid, drain every pending result, then give the sequencer time to return home
    task automatic settle();
        s_valid <= 1'b0;
        while (chk_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_TICKS) @(posedge aclk);
    endtask

    // One register access: setup cycle, then access cycle until pready
    task automatic apb_xfer(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write the mode with random upper bits, read it back and switch the tracker over
    task automatic set_mode(input logic m);
        logic [31:0] wdata;
        logic [31:0] rdata;
        wdata    = $urandom();
        wdata[0] = m;
        apb_xfer(1'b1, MODE_ADDR, wdata, rdata);
        apb_xfer(1'b0, MODE_ADDR, 32'd0, rdata);
        if (rdata !== {31'd0, m})
            note_fault($sformatf("mode read back %h, expected %h", rdata, {31'd0, m}));
        mode_verify = m;
    endtask

    // ------------------------------------------------------------------
    // Random message builder
    // ------------------------------------------------------------------
    task automatic build_message();
        int          shape;
        int          pick;
        int          plen;
        int          flip;
        logic [7:0]  ch;
        logic [7:0]  ver;
        logic [7:0]  v;
        logic [29:0] acc;
        bit          with_ver;
        logic [7:0]  hrp [$];
        logic [4:0]  syms [$];
        msg_q.delete();
        shape = $urandom_range(0, 99);
        ver   = 8'd0;
        if (shape < 80) begin
            // Well-formed: prefix, optional version, payload; verify mode appends a
            // checksum that is right three times out of four
            pick = $urandom_range(0, 99);
            plen = (pick < 85) ? $urandom_range(1, 8)
                 : (pick < 97) ? $urandom_range(9, 40) : $urandom_range(100, HRP_MAX);
            repeat (plen) begin
                ch = 8'($urandom_range(0, 255));
                hrp.push_back(ch);
                msg_q.push_back(mk_item(KIND_PREFIX, ch));
            end
            with_ver = $urandom_range(0, 3) != 0;
            if (with_ver) begin
                if (mode_verify)
                    ver = {3'($urandom_range(0, 7)),
                           ($urandom_range(0, 2) == 0) ? 5'd0 : 5'($urandom_range(1, 31))};
                else
                    ver = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
                msg_q.push_back(mk_item(KIND_VERSION, ver));
                syms.push_back(ver[4:0]);
            end
            repeat ($urandom_range(0, 12)) begin
                v = 8'($urandom_range(0, 255));
                msg_q.push_back(mk_item(KIND_PAYLOAD, v));
                syms.push_back(v[4:0]);
            end
            if (mode_verify) begin
                acc = BECH32_K;
                foreach (hrp[i]) acc = bch_mix(acc, {2'b00, hrp[i][7:5]});
                acc = bch_mix(acc, 5'd0);
                foreach (hrp[i]) acc = bch_mix(acc, hrp[i][4:0]);
                foreach (syms[i]) acc = bch_mix(acc, syms[i]);
                repeat (CHK_LEN) acc = bch_mix(acc, 5'd0);
                acc ^= (with_ver && ver[4:0] != 5'd0) ? BECH32M_K : BECH32_K;
                if ($urandom_range(0, 3) == 0) begin
                    flip = $urandom_range(0, 29);
                    acc[flip] = ~acc[flip];
                end
                for (int k = 0; k < CHK_LEN; k++)
                    msg_q.push_back(mk_item(KIND_PAYLOAD,
                                            {3'($urandom_range(0, 7)), acc[29-5*k -: 5]}));
            end
        end else if (shape < 85) begin
            // Run the prefix store close to, up to and past its limit
            repeat ($urandom_range(HRP_MAX - 2, HRP_MAX + 6))
                msg_q.push_back(mk_item(KIND_PREFIX, 8'($urandom_range(0, 255))));
            if ($urandom_range(0, 1) == 1)
                msg_q.push_back(mk_item(KIND_PAYLOAD, 8'($urandom_range(0, 255))));
        end else if (shape < 90) begin
            // Prefix characters arriving after the data has started
            repeat ($urandom_range(1, 6))
                msg_q.push_back(mk_item(KIND_PREFIX, 8'($urandom_range(0, 255))));
            msg_q.push_back(mk_item(2'($urandom_range(1, 2)), 8'($urandom_range(0, 255))));
            repeat ($urandom_range(1, 2))
                msg_q.push_back(mk_item(KIND_PREFIX, 8'($urandom_range(0, 255))));
            if ($urandom_range(0, 1) == 1)
                msg_q.push_back(mk_item(KIND_PAYLOAD, 8'($urandom_range(0, 255))));
        end else if (shape < 95) begin
            // Finish straight after the prefix, possibly an empty one
            repeat ($urandom_range(0, 6))
                msg_q.push_back(mk_item(KIND_PREFIX, 8'($urandom_range(0, 255))));
        end else begin
            // Noise: any mix of non-finish items, repeated versions included
            repeat ($urandom_range(1, 8))
                msg_q.push_back(mk_item(2'($urandom_range(0, 2)), 8'($urandom_range(0, 255))));
        end
        msg_q.push_back(mk_item(KIND_FINISH, 8'($urandom_range(0, 255))));
    endtask

    // ------------------------------------------------------------------
    // Result channel: random back-pressure plus one long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        int gap;
        m_ready <= 1'b0;
        rx_calm = 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (hold_req) begin
                // Hold off long enough for the engine to fill up and stall its input
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_TICKS) @(posedge aclk);
            end
            if ($urandom_range(0, 11) == 0) rx_calm = !rx_calm;
            gap = rx_calm ? 0 : $urandom_range(0, 8);
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1 && !hold_req);
        end
    end

    // Scoreboard: compare every result transfer with the oldest expectation
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            rx_count++;
            if (chk_due.size() == 0) begin
                note_fault($sformatf("unexpected result sym=%0d pass=%0d err=%0d last=%0d",
                                     m_data.symbol, m_data.passed, m_data.error,
                                     m_data.last));
            end else begin
                want = chk_due.pop_front();
                if (want.passed) pass_count++;
                if (want.error) err_count++;
                if (m_data.symbol !== want.symbol || m_data.passed !== want.passed ||
                    m_data.error !== want.error || m_data.last !== want.last)
                    note_fault($sformatf(
                        "expected s=%0d p=%0d e=%0d l=%0d, got s=%0d p=%0d e=%0d l=%0d",
                        want.symbol, want.passed, want.error, want.last,
                        m_data.symbol, m_data.passed, m_data.error, m_data.last));
            end
        end
    end

    // Watchdog: stop a hung run
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles, %0d results outstanding", cycles,
                     chk_due.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int sent_here;
        int msgs_here;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        hold_req = 1'b0;
        tx_calm  = 1'b0;
        mode_verify = 1'b0;
        clear_msg();

        // Directed table, generate mode first (the reset setting)
        add_row(0, KIND_FINISH,  8'h00);                  // nothing at all before finish
        add_row(0, KIND_PREFIX,  8'h00);
        add_row(0, KIND_PREFIX,  8'hff);
        add_row(0, KIND_VERSION, 8'h20);                  // low bits zero, byte non-zero
        add_row(0, KIND_PAYLOAD, 8'hff);
        add_row(0, KIND_PREFIX,  8'h41);                  // prefix after data: flagged
        add_row(0, KIND_FINISH,  8'hff);
        add_row(0, KIND_PREFIX,  8'h7e);
        add_row(0, KIND_VERSION, 8'h00);                  // plain bech32 constant
        add_row(0, KIND_PAYLOAD, 8'h1f);
        add_row(0, KIND_FINISH,  8'h00);
        add_row(1, KIND_PREFIX,  8'h01);                  // switch to verify
        add_row(0, KIND_FINISH,  8'h00, 1, 1, VERDICT_EMPTY);
        add_row(0, KIND_PREFIX,  8'h61);                  // a known-good bech32 string
        add_row(0, KIND_PAYLOAD, 8'd10);
        add_row(0, KIND_PAYLOAD, 8'd28);
        add_row(0, KIND_PAYLOAD, 8'd25);
        add_row(0, KIND_PAYLOAD, 8'd31);
        add_row(0, KIND_PAYLOAD, 8'd20);
        add_row(0, KIND_PAYLOAD, 8'd31);
        add_row(0, KIND_FINISH,  8'h00);
        add_row(0, KIND_VERSION, 8'h20);                  // empty prefix fails
        add_row(0, KIND_FINISH,  8'h00, 1, 1, VERDICT_EMPTY);
        add_row(0, KIND_PREFIX,  8'h71);                  // no data fails
        add_row(0, KIND_FINISH,  8'h00, 1, 1, VERDICT_EMPTY);
        add_row(0, KIND_PREFIX,  8'h7a, HRP_MAX + 1);     // one past the prefix store
        add_row(0, KIND_FINISH,  8'h00, 1, 1, VERDICT_EMPTY_ERR);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Walk the table
        foreach (dir_rows[i]) begin
            if (dir_rows[i].cfg) begin
                settle();
                set_mode(dir_rows[i].item.value[0]);
            end else begin
                repeat (dir_rows[i].reps)
                    send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
            end
        end

        // Random messages, verify then generate; the generate phase meets a long hold-off
        // from its start, with at least two messages so the sender keeps offering
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            settle();
            set_mode((ph % 2 == 0) ? 1'b1 : 1'b0);
            if (ph == 1) hold_req = 1'b1;
            sent_here = 0;
            msgs_here = 0;
            while (sent_here < PHASE_ITEMS || msgs_here < 2) begin
                build_message();
                tx_calm = $urandom_range(0, 3) == 0;
                foreach (msg_q[i]) send_item(msg_q[i]);
                sent_here += msg_q.size();
                msgs_here++;
                msg_count++;
            end
        end

        settle();
        $display("Covered %0d random messages in both modes, %0d input and %0d result transfers.",
                 msg_count, tx_count, rx_count);
        $display("Verify passes %0d, error-flagged results %0d, faults %0d.",
                 pass_count, err_count, faults);
        if (faults == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
